@@ rtl/core/time_slice_task_scheduler_assert.svh @@
// Assertion macros for the time-slice task scheduler checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH
`define TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tsts_pkg.sv @@
// Shared types and constants of the time-slice task scheduler.
// No dependencies; used by the cell, the top level and the checker.
`timescale 1ns / 1ps

package tsts_pkg;

  // Priority of task 0 after reset.
  localparam logic [7:0] FIRST_PRIO_RESET = 8'd15;

  typedef enum logic {
    KIND_TICK   = 1'b0,
    KIND_CREATE = 1'b1
  } kind_e;

  // One input beat.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] priority_req;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  current_task;
    logic        switched;
    logic [2:0]  created_id;
    logic        create_failed;
    logic [31:0] current_run_ticks;
  } res_t;

  // Operation broadcast to the row of task cells.
  typedef enum logic [1:0] {
    CELL_NOP    = 2'd0,
    CELL_CREATE = 2'd1,
    CELL_TICK   = 2'd2,
    CELL_CFG    = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] prio;
  } cell_cmd_t;

  // What each cell shows to the sequencer.
  typedef struct packed {
    logic [8:0]  slice;
    logic [31:0] ticks;
  } cell_stat_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_REFILL,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/tsts_cell.sv @@
// One task cell: priority, remaining slice, run ticks and a table-valid bit.
// Refill token enters from the left neighbor and leaves to the right one.
// Depends on tsts_pkg.
`timescale 1ns / 1ps

module tsts_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IdxW    = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsts_pkg::cell_cmd_t  cmd_i,
  input  logic [IdxW-1:0]      sel_i,
  input  logic                 tok_i,
  output logic                 tok_o,
  output tsts_pkg::cell_stat_t stat_o
);

  logic        hit;
  logic        valid_q;
  logic        tok_q;
  logic [7:0]  prio_q;
  logic [8:0]  slice_q;
  logic [31:0] ticks_q;

  assign hit = (sel_i == IdxW'(CellIdx));

  // Task state. Commands address one cell; the refill token visits each in turn.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= (CellIdx == 0);
      prio_q  <= (CellIdx == 0) ? tsts_pkg::FIRST_PRIO_RESET : 8'd0;
      slice_q <= '0;
      ticks_q <= '0;
    end else if (tok_i) begin
      if (valid_q) begin
        slice_q <= 9'(prio_q) + (slice_q >> 1);
      end
    end else if (hit) begin
      unique case (cmd_i.op)
        tsts_pkg::CELL_CREATE: begin
          valid_q <= 1'b1;
          prio_q  <= cmd_i.prio;
          slice_q <= '0;
          ticks_q <= '0;
        end
        tsts_pkg::CELL_TICK: begin
          ticks_q <= ticks_q + 32'd1;
          slice_q <= (slice_q > 9'd1) ? slice_q - 9'd1 : 9'd0;
        end
        tsts_pkg::CELL_CFG: begin
          prio_q <= cmd_i.prio;
        end
        tsts_pkg::CELL_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Token register hands the refill to the right neighbor in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign tok_o        = tok_q;
  assign stat_o.slice = slice_q;
  assign stat_o.ticks = ticks_q;

endmodule

@@ rtl/core/time_slice_task_scheduler.sv @@
// Time-slice task scheduler top level: sequencer plus a row of task cells.
// Depends on tsts_pkg and tsts_cell.
`timescale 1ns / 1ps
//
// Usage:
// An item (req_i) is taken at a clock edge where start is high and busy
// is low. busy stays high until the result beat has been shown. Each item
// yields one result beat on res_o, marked by res_valid_o for one cycle; the
// receiver must take it then.
// States: a create or a tick that does not end a slice passes EXEC, then
// shows its result in DONE; a slice end without refill also passes CHECK.
// A slice end that needs a refill walks the refill token down the row of
// MAX_TASKS cells, one cell per cycle, in state REFILL, and shows its result
// in DONE once the token leaves the last cell. A new item is taken only
// after the result, back in IDLE; the refill walk makes the longest item.
// cfg_we_i/cfg_wdata_i write the priority of task 0 while the block is idle.
// Reset: task 0 alone, priority 15, all slices and tick counts zero.

module time_slice_task_scheduler #(
  parameter int unsigned MAX_TASKS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tsts_pkg::req_t   req_i,
  output logic             res_valid_o,
  output tsts_pkg::res_t   res_o,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = IdxW + 1;

  tsts_pkg::state_e     state_q, state_d;
  tsts_pkg::req_t       req_q;
  logic [CntW-1:0]      task_count_q;
  logic [IdxW-1:0]      running_q;
  logic                 end_q;
  logic                 switched_q;
  logic                 fail_q;
  logic [IdxW-1:0]      cid_q;

  tsts_pkg::cell_cmd_t  cmd;
  logic [IdxW-1:0]      sel;
  logic [MAX_TASKS:0]   tok;
  tsts_pkg::cell_stat_t stat [MAX_TASKS];

  logic                 accept;
  logic                 full;
  logic [CntW-1:0]      nxt_ext;
  logic [IdxW-1:0]      nxt;
  logic                 refill_start;

  assign accept = start && !busy;
  assign full   = (task_count_q == CntW'(MAX_TASKS));

  // Next task in table order, wrapping to task 0.
  assign nxt_ext = {1'b0, running_q} + CntW'(1);
  assign nxt     = (nxt_ext >= task_count_q) ? '0 : nxt_ext[IdxW-1:0];

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsts_pkg::ST_IDLE: begin
        if (accept) state_d = tsts_pkg::ST_EXEC;
      end
      tsts_pkg::ST_EXEC: begin
        if ((req_q.kind == tsts_pkg::KIND_TICK) &&
            (stat[running_q].slice <= 9'd1)) begin
          state_d = tsts_pkg::ST_CHECK;
        end else begin
          state_d = tsts_pkg::ST_DONE;
        end
      end
      tsts_pkg::ST_CHECK: begin
        state_d = (stat[nxt].slice == 9'd0) ? tsts_pkg::ST_REFILL : tsts_pkg::ST_DONE;
      end
      tsts_pkg::ST_REFILL: begin
        if (tok[MAX_TASKS]) state_d = tsts_pkg::ST_DONE;
      end
      tsts_pkg::ST_DONE: begin
        state_d = tsts_pkg::ST_IDLE;
      end
      default: state_d = tsts_pkg::ST_IDLE;
    endcase
  end

  // Output logic: handshake, cell command and refill launch.
  always_comb begin
    busy         = (state_q != tsts_pkg::ST_IDLE);
    res_valid_o  = (state_q == tsts_pkg::ST_DONE);
    cmd.op       = tsts_pkg::CELL_NOP;
    cmd.prio     = req_q.priority_req;
    sel          = running_q;
    refill_start = 1'b0;
    unique case (state_q)
      tsts_pkg::ST_IDLE: begin
        if (cfg_we_i) begin
          cmd.op   = tsts_pkg::CELL_CFG;
          cmd.prio = cfg_wdata_i;
          sel      = '0;
        end
      end
      tsts_pkg::ST_EXEC: begin
        if (req_q.kind == tsts_pkg::KIND_CREATE) begin
          if (!full) begin
            cmd.op = tsts_pkg::CELL_CREATE;
            sel    = task_count_q[IdxW-1:0];
          end
        end else begin
          cmd.op = tsts_pkg::CELL_TICK;
        end
      end
      tsts_pkg::ST_CHECK: begin
        refill_start = (stat[nxt].slice == 9'd0);
      end
      tsts_pkg::ST_REFILL, tsts_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Input beat capture.
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
  end

  // Sequencer and scheduler control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsts_pkg::ST_IDLE;
      task_count_q <= CntW'(1);
      running_q    <= '0;
      end_q        <= 1'b0;
      switched_q   <= 1'b0;
      fail_q       <= 1'b0;
      cid_q        <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        tsts_pkg::ST_IDLE: begin
          if (accept) begin
            switched_q <= 1'b0;
            fail_q     <= 1'b0;
            cid_q      <= '0;
            end_q      <= 1'b0;
          end
        end
        tsts_pkg::ST_EXEC: begin
          if (req_q.kind == tsts_pkg::KIND_CREATE) begin
            if (full) begin
              fail_q <= 1'b1;
            end else begin
              cid_q        <= task_count_q[IdxW-1:0];
              task_count_q <= task_count_q + CntW'(1);
            end
          end else begin
            end_q <= (stat[running_q].slice <= 9'd1);
          end
        end
        tsts_pkg::ST_CHECK: begin
          switched_q <= 1'b1;
          running_q  <= (stat[nxt].slice == 9'd0) ? '0 : nxt;
        end
        tsts_pkg::ST_REFILL, tsts_pkg::ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Row of task cells; the refill token runs from cell 0 to the last cell.
  assign tok[0] = refill_start;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    tsts_cell #(
      .CellIdx(i),
      .IdxW   (IdxW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .sel_i (sel),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .stat_o(stat[i])
    );
  end

  // Result beat, built from the settled state.
  assign res_o.current_task      = 3'(running_q);
  assign res_o.switched          = switched_q && end_q;
  assign res_o.created_id        = 3'(cid_q);
  assign res_o.create_failed     = fail_q;
  assign res_o.current_run_ticks = stat[running_q].ticks;

endmodule

@@ rtl/core/tsts_checker.sv @@
// Port-level checker for the time-slice task scheduler, bound to the top level.
// Depends on tsts_pkg and time_slice_task_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "time_slice_task_scheduler_assert.svh"

module tsts_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_valid_o,
  input tsts_pkg::res_t res_o
);

  // An accepted beat makes the block busy and gives no result in the next cycle.
  `TSTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `TSTS_ASSERT_NEXT(a_no_early_res, start && !busy, !res_valid_o, "result right after accept")

  // A result is shown only while busy, and the block is free right after it.
  `TSTS_ASSERT_NOW(a_res_busy, res_valid_o, busy, "result shown while not busy")
  `TSTS_ASSERT_NEXT(a_res_release, res_valid_o, !busy, "busy held after result")

  // A failed create names no task and never switches.
  `TSTS_ASSERT_NOW(a_fail_fields, res_valid_o && res_o.create_failed,
    (res_o.created_id == 3'd0) && !res_o.switched, "failed create fields not zero")

endmodule

bind time_slice_task_scheduler tsts_checker u_tsts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

@@ test/tb.sv @@
// Self-checking testbench for the time-slice task scheduler.
// Depends on tsts_pkg and the time_slice_task_scheduler top level; the
// expected result beats come from a scheduler predictor inside this file.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_TASKS = 8;

  // One entry of the stimulus list: a request beat or a priority write.
  typedef struct {
    bit               is_cfg;
    tsts_pkg::req_t   req;
    logic [7:0]       wdata;
    int unsigned      idle_pct;
  } sched_cmd_t;

  logic           clk_i;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  tsts_pkg::req_t req_i = '0;
  logic           res_valid_o;
  tsts_pkg::res_t res_o;
  logic           cfg_we_i = 1'b0;
  logic [7:0]     cfg_wdata_i = '0;

  // Predicted scheduler state.
  logic [7:0]  prio_tbl  [NUM_TASKS];
  logic [8:0]  slice_tbl [NUM_TASKS];
  logic [31:0] ticks_tbl [NUM_TASKS];
  int unsigned task_cnt;
  int unsigned run_idx;

  sched_cmd_t     sched_cmd_q[$];
  tsts_pkg::res_t sched_result_q[$];
  int unsigned    gen_idle_pct;
  bit             failed;

  // Driver scratch values, so each input gets one assignment per edge.
  sched_cmd_t     drv_cmd;
  tsts_pkg::res_t drv_res;
  logic           drv_start;
  tsts_pkg::req_t drv_req;
  logic           drv_we;
  logic [7:0]     drv_wdata;

  time_slice_task_scheduler #(
    .MAX_TASKS(NUM_TASKS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the predicted state and return the result beat.
  function void schedule_beat(input tsts_pkg::req_t rq, output tsts_pkg::res_t rs);
    int unsigned cur;
    int unsigned nx;
    int unsigned t;
    logic        sw;
    logic        fail;
    logic [2:0]  cid;
    sw   = 1'b0;
    fail = 1'b0;
    cid  = '0;
    if (run_idx >= task_cnt) run_idx = 0;
    cur = run_idx;
    if (rq.kind == tsts_pkg::KIND_CREATE) begin
      if (task_cnt >= NUM_TASKS) begin
        fail = 1'b1;
      end else begin
        prio_tbl[task_cnt]  = rq.priority_req;
        slice_tbl[task_cnt] = '0;
        ticks_tbl[task_cnt] = '0;
        cid = task_cnt[2:0];
        task_cnt++;
      end
    end else begin
      ticks_tbl[cur] = ticks_tbl[cur] + 32'd1;
      if (slice_tbl[cur] > 9'd1) begin
        slice_tbl[cur] = slice_tbl[cur] - 9'd1;
      end else begin
        // Slice is over: move on, or refill everything and go back to task 0.
        slice_tbl[cur] = '0;
        nx = cur + 1;
        if (nx >= task_cnt) nx = 0;
        if (slice_tbl[nx] == '0) begin
          for (t = 0; t < task_cnt; t++)
            slice_tbl[t] = {1'b0, prio_tbl[t]} + (slice_tbl[t] >> 1);
          nx = 0;
        end
        run_idx = nx;
        sw = 1'b1;
      end
    end
    rs.current_task      = run_idx[2:0];
    rs.switched          = sw;
    rs.created_id        = cid;
    rs.create_failed     = fail;
    rs.current_run_ticks = ticks_tbl[run_idx];
  endfunction

  function void push_item(input tsts_pkg::kind_e kind, input logic [7:0] prio);
    sched_cmd_t c;
    c.is_cfg           = 1'b0;
    c.req.kind         = kind;
    c.req.priority_req = prio;
    c.wdata            = '0;
    c.idle_pct         = gen_idle_pct;
    sched_cmd_q.push_back(c);
  endfunction

  function void push_cfg(input logic [7:0] value);
    sched_cmd_t c;
    c.is_cfg   = 1'b1;
    c.req      = '0;
    c.wdata    = value;
    c.idle_pct = 0;
    sched_cmd_q.push_back(c);
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      failed = 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Driver: present request beats and priority writes from the stimulus list.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      req_i       <= '0;
      cfg_we_i    <= 1'b0;
      cfg_wdata_i <= '0;
    end else begin
      drv_start = start;
      drv_req   = req_i;
      drv_we    = 1'b0;
      drv_wdata = cfg_wdata_i;
      // A beat taken at this edge goes through the predictor.
      if (start && !busy) begin
        schedule_beat(req_i, drv_res);
        sched_result_q.push_back(drv_res);
        drv_start = 1'b0;
      end
      if (!drv_start && sched_cmd_q.size() != 0) begin
        drv_cmd = sched_cmd_q[0];
        if (drv_cmd.is_cfg) begin
          // Priority writes only go out once the block has drained.
          if (sched_result_q.size() == 0 && !busy) begin
            drv_we      = 1'b1;
            drv_wdata   = drv_cmd.wdata;
            prio_tbl[0] = drv_cmd.wdata;
            void'(sched_cmd_q.pop_front());
          end
        end else if ($urandom_range(99) >= drv_cmd.idle_pct) begin
          drv_start = 1'b1;
          drv_req   = drv_cmd.req;
          void'(sched_cmd_q.pop_front());
        end
      end
      start       <= drv_start;
      req_i       <= drv_req;
      cfg_we_i    <= drv_we;
      cfg_wdata_i <= drv_wdata;
    end
  end

  // Monitor: results are sampled mid-cycle, away from the driving edge.
  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (sched_result_q.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, res_o);
      end else begin
        drv_res = sched_result_q.pop_front();
        check_field("current_task", drv_res.current_task, res_o.current_task);
        check_field("switched", drv_res.switched, res_o.switched);
        check_field("created_id", drv_res.created_id, res_o.created_id);
        check_field("create_failed", drv_res.create_failed, res_o.create_failed);
        check_field("current_run_ticks", drv_res.current_run_ticks,
                    res_o.current_run_ticks);
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      prio_tbl[i]  = '0;
      slice_tbl[i] = '0;
      ticks_tbl[i] = '0;
    end
    prio_tbl[0]  = tsts_pkg::FIRST_PRIO_RESET;
    task_cnt     = 1;
    run_idx      = 0;
    failed       = 1'b0;

    // Directed: lone task 0, priority extremes, fill the table, then overflow.
    gen_idle_pct = 0;
    push_item(tsts_pkg::KIND_TICK, 8'hFF);
    push_item(tsts_pkg::KIND_TICK, 8'h00);
    push_cfg(8'd0);
    push_item(tsts_pkg::KIND_TICK, 8'h55);
    push_item(tsts_pkg::KIND_CREATE, 8'd1);
    push_item(tsts_pkg::KIND_CREATE, 8'd2);
    push_item(tsts_pkg::KIND_CREATE, 8'd3);
    push_item(tsts_pkg::KIND_CREATE, 8'd1);
    push_item(tsts_pkg::KIND_CREATE, 8'd2);
    // A zero-priority task starves the one behind it, so the 255-priority
    // task keeps collecting half-slices until its slice settles at 509, just under the 9-bit ceiling.
    push_item(tsts_pkg::KIND_CREATE, 8'd0);
    push_item(tsts_pkg::KIND_CREATE, 8'hFF);
    push_item(tsts_pkg::KIND_CREATE, 8'hAA);
    push_item(tsts_pkg::KIND_CREATE, 8'h55);
    repeat (8) push_item(tsts_pkg::KIND_TICK, 8'($urandom_range(255)));
    push_cfg(8'hFF);
    repeat (2) push_item(tsts_pkg::KIND_TICK, 8'($urandom_range(255)));
    push_cfg(8'd1);

    // Random: mostly ticks, some creates on the full table.
    for (int p = 0; p < 3; p++) begin
      gen_idle_pct = (p == 0) ? 8 : (p == 1) ? 45 : 0;
      push_cfg(8'($urandom_range(6)));
      repeat (160)
        push_item(($urandom_range(99) < 10) ? tsts_pkg::KIND_CREATE
                                            : tsts_pkg::KIND_TICK,
                  8'($urandom_range(255)));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sched_cmd_q.size() != 0 || start || sched_result_q.size() != 0)
      @(negedge clk_i);
    repeat (NUM_TASKS + 8) @(negedge clk_i);

    if (failed)
      $display("*** FAILED ***");
    else
      $display("*** PASSED ***");
    $finish;
  end

  // Hang guard.
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
